// ----- rtl/aiffw_pkg.sv -----
// ----------------------------------------------------------------------------
// aiffw_pkg
// Types and constants for the AIFF PCM stream writer: item structs,
// configuration register indexes, chunk identifiers and quantiser limits.
// ----------------------------------------------------------------------------
package aiffw_pkg;

    // Input item: start of file or one Q2.30 sample
    typedef struct packed {
        logic              func;
        logic signed [31:0] sample;
    } in_item_t;

    // Output item: one byte of the file
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } out_item_t;

    // Function codes of an input item
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        CFG_SAMPLE_FORMAT = 2'd0,
        CFG_CHANNEL_COUNT = 2'd1,
        CFG_FRAME_COUNT   = 2'd2,
        CFG_SAMPLE_RATE   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        JOB_HEADER = 2'd0,
        JOB_SAMPLE = 2'd1,
        JOB_ERROR  = 2'd2
    } job_kind_t;

    localparam int HDR_BYTES = 54;
    localparam int HDR_BITS  = HDR_BYTES * 8;

    localparam logic [31:0] ID_FORM = 32'h464F_524D;
    localparam logic [31:0] ID_AIFF = 32'h4149_4646;
    localparam logic [31:0] ID_COMM = 32'h434F_4D4D;
    localparam logic [31:0] ID_SSND = 32'h5353_4E44;

    localparam logic [31:0] COMM_SIZE = 32'd18;
    localparam logic [31:0] FORM_BASE = 32'(HDR_BYTES - 8);
    localparam logic [31:0] SSND_BASE = 32'd8;

    localparam logic [15:0] BITS_16 = 16'd16;
    localparam logic [15:0] BITS_24 = 16'd24;

    // Extended float exponent for a leading one at bit 31
    localparam int          EXP_BIAS = 16382;
    localparam logic [14:0] EXP_TOP  = 15'(EXP_BIAS + 32);

    localparam logic signed [26:0] LIM16_HI = 27'sd32767;
    localparam logic signed [26:0] LIM16_LO = -27'sd32768;
    localparam logic signed [26:0] LIM24_HI = 27'sd8388607;
    localparam logic signed [26:0] LIM24_LO = -27'sd8388608;

    localparam logic [31:0] RATE_RESET = 32'd44100;
    localparam logic [15:0] CHAN_RESET = 16'd1;

endpackage

// ----- rtl/aiff_pcm_stream_writer.sv -----
// ----------------------------------------------------------------------------
// aiff_pcm_stream_writer
// Turns start and sample items into the bytes of an AIFF PCM file.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : valid/ready items; func = 0 starts a file, func = 1 carries one
//           Q2.30 sample in frame-major interleaved order.
//   out_* : valid/ready items, one file byte each, with last and error flags.
//   cfg_* : register writes (format, channels, frames, rate), taken at once;
//           write only while the block is idle.
// Timing
//   An item passes an input register and a job register; its first byte then
//   reaches the output register. The job register sends one byte per cycle
//   while the receiver takes them, so a start sends 54 header bytes, a 16-bit
//   sample 2 and a 24-bit sample 3 (4 with the pad byte). The next item is
//   taken while the current one finishes. After a register write in_ready
//   drops while the frame product settles; after a sample_rate write (and
//   after reset) it stays low until the leading-one search finishes, one bit
//   per cycle.
// Reset clears any open file. A stalled receiver holds the output register,
// and the job and input registers fill behind it before in_ready drops.
// ----------------------------------------------------------------------------
module aiff_pcm_stream_writer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  aiffw_pkg::in_item_t    in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output aiffw_pkg::out_item_t   out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  aiffw_pkg::cfg_index_t  cfg_index,
    input  logic [31:0]            cfg_data
);
    import aiffw_pkg::*;

    // Configuration and derived sizes
    logic        sample_format_reg, sample_format_next;
    logic [15:0] channel_count_reg, channel_count_next;
    logic [31:0] frame_count_reg, frame_count_next;
    logic [47:0] total_reg;
    logic [49:0] sound_reg;
    logic [1:0]  settle_reg, settle_next;
    logic [31:0] mant_reg, mant_next;
    logic [14:0] expo_reg, expo_next;
    logic        norm_busy_reg, norm_busy_next;

    // File state
    logic        file_open_reg, file_open_next;
    logic [47:0] samples_left_reg, samples_left_next;
    logic        fmt24_reg, fmt24_next;
    logic        pad_reg, pad_next;

    // Pipeline registers
    logic        in_valid_reg, in_valid_next;
    in_item_t    in_item_reg;
    logic        job_valid_reg, job_valid_next;
    job_kind_t   job_kind_reg, job_kind_next;
    logic [5:0]  job_len_reg, job_len_next;
    logic [5:0]  job_idx_reg, job_idx_next;
    logic [23:0] job_val_reg, job_val_next;
    logic        job_fmt24_reg, job_fmt24_next;
    logic        job_end_reg, job_end_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;

    logic        cfg_fire, in_fire, emit_fire, job_done, job_free, in_move, final_smp;

    // Quantiser
    logic [55:0]        s_ext, prod;
    logic [25:0]        q_floor;
    logic [29:0]        q_rem;
    logic               q_inc;
    logic signed [26:0] q_round, q_clamp, lim_hi, lim_lo;

    // Header
    logic [HDR_BITS-1:0] hdr;
    logic [31:0]         form_size, ssnd_size;
    logic [8:0]          hdr_pos;
    logic [7:0]          byte_sel;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    assign emit_fire = job_valid_reg && (!out_valid_reg || out_ready);
    assign job_done  = emit_fire && (job_idx_reg == job_len_reg - 6'd1);
    assign job_free  = !job_valid_reg || job_done;
    assign in_move   = in_valid_reg && job_free;
    assign in_ready  = (!in_valid_reg || in_move) && (settle_reg == 2'd0) && !norm_busy_reg;
    assign in_fire   = in_valid && in_ready;
    assign final_smp = (samples_left_reg == 48'd1);

    // sample * limit as a shift and subtract, then round half to even and clamp
    always_comb
    begin
        s_ext   = {{24{in_item_reg.sample[31]}}, in_item_reg.sample};
        prod    = fmt24_reg ? ((s_ext << 23) - s_ext) : ((s_ext << 15) - s_ext);
        q_floor = prod[55:30];
        q_rem   = prod[29:0];
        q_inc   = q_rem[29] && ((q_rem[28:0] != 29'd0) || q_floor[0]);
        q_round = $signed({q_floor[25], q_floor}) + $signed({26'd0, q_inc});
        lim_hi  = fmt24_reg ? LIM24_HI : LIM16_HI;
        lim_lo  = fmt24_reg ? LIM24_LO : LIM16_LO;
        if (q_round > lim_hi)
        begin
            q_clamp = lim_hi;
        end
        else if (q_round < lim_lo)
        begin
            q_clamp = lim_lo;
        end
        else
        begin
            q_clamp = q_round;
        end
    end

    // Header image, built from registers the user must hold while a file is sent (not enforced here)
    always_comb
    begin
        form_size = FORM_BASE + sound_reg[31:0] + {31'd0, sound_reg[0]};
        ssnd_size = SSND_BASE + sound_reg[31:0];
        hdr = {ID_FORM, form_size, ID_AIFF,
               ID_COMM, COMM_SIZE, channel_count_reg, frame_count_reg,
               (sample_format_reg ? BITS_24 : BITS_16),
               {1'b0, expo_reg}, mant_reg, 32'd0,
               ID_SSND, ssnd_size, 32'd0, 32'd0};
        hdr_pos = {6'(HDR_BYTES - 1) - job_idx_reg, 3'b000};
    end

    // Byte of the current job
    always_comb
    begin
        byte_sel = 8'd0;
        case (job_kind_reg)
            JOB_HEADER:
            begin
                byte_sel = hdr[hdr_pos +: 8];
            end
            JOB_SAMPLE:
            begin
                case (job_idx_reg)
                    6'd0:    byte_sel = job_fmt24_reg ? job_val_reg[23:16] : job_val_reg[15:8];
                    6'd1:    byte_sel = job_fmt24_reg ? job_val_reg[15:8] : job_val_reg[7:0];
                    6'd2:    byte_sel = job_fmt24_reg ? job_val_reg[7:0] : 8'd0;
                    default: byte_sel = 8'd0;
                endcase
            end
            default:
            begin
                byte_sel = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        sample_format_next = sample_format_reg;
        channel_count_next = channel_count_reg;
        frame_count_next   = frame_count_reg;
        settle_next        = (settle_reg != 2'd0) ? settle_reg - 2'd1 : settle_reg;
        mant_next          = mant_reg;
        expo_next          = expo_reg;
        norm_busy_next     = norm_busy_reg;

        // Leading-one search: advance one bit a cycle
        if (norm_busy_reg)
        begin
            if (mant_reg[31])
            begin
                norm_busy_next = 1'b0;
            end
            else
            begin
                mant_next = {mant_reg[30:0], 1'b0};
                expo_next = expo_reg - 15'd1;
            end
        end

        if (cfg_fire)
        begin
            settle_next = 2'd2;
            case (cfg_index)
                CFG_SAMPLE_FORMAT: sample_format_next = cfg_data[0];
                CFG_CHANNEL_COUNT: channel_count_next = cfg_data[15:0];
                CFG_FRAME_COUNT:   frame_count_next   = cfg_data;
                CFG_SAMPLE_RATE:
                begin
                    mant_next      = cfg_data;
                    expo_next      = (cfg_data == 32'd0) ? 15'd0 : EXP_TOP;
                    norm_busy_next = (cfg_data != 32'd0);
                end
                default: settle_next = 2'd2;
            endcase
        end
    end

    always_comb
    begin
        file_open_next    = file_open_reg;
        samples_left_next = samples_left_reg;
        fmt24_next        = fmt24_reg;
        pad_next          = pad_reg;
        in_valid_next     = in_valid_reg;
        job_valid_next    = job_valid_reg && !job_done;
        job_kind_next     = job_kind_reg;
        job_len_next      = job_len_reg;
        job_idx_next      = emit_fire ? job_idx_reg + 6'd1 : job_idx_reg;
        job_val_next      = job_val_reg;
        job_fmt24_next    = job_fmt24_reg;
        job_end_next      = job_end_reg;
        out_valid_next    = out_valid_reg;
        out_item_next     = out_item_reg;

        if (in_move)
        begin
            in_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end

        if (in_move)
        begin
            if (in_item_reg.func == FUNC_START)
            begin
                job_valid_next = 1'b1;
                job_idx_next   = 6'd0;
                if (channel_count_reg == 16'd0)
                begin
                    file_open_next    = 1'b0;
                    samples_left_next = 48'd0;
                    job_kind_next     = JOB_ERROR;
                    job_len_next      = 6'd1;
                    job_end_next      = 1'b0;
                end
                else
                begin
                    fmt24_next        = sample_format_reg;
                    pad_next          = sound_reg[0];
                    samples_left_next = total_reg;
                    file_open_next    = (total_reg != 48'd0);
                    job_kind_next     = JOB_HEADER;
                    job_len_next      = 6'(HDR_BYTES);
                    job_end_next      = (total_reg == 48'd0);
                end
            end
            else if (file_open_reg && (samples_left_reg != 48'd0))
            begin
                samples_left_next = samples_left_reg - 48'd1;
                file_open_next    = !final_smp;
                job_valid_next    = 1'b1;
                job_idx_next      = 6'd0;
                job_kind_next     = JOB_SAMPLE;
                job_len_next      = (fmt24_reg ? 6'd3 : 6'd2) + {5'd0, final_smp && pad_reg};
                job_end_next      = final_smp;
                job_val_next      = q_clamp[23:0];
                job_fmt24_next    = fmt24_reg;
            end
            // otherwise drop the sample
        end

        if (emit_fire)
        begin
            out_valid_next         = 1'b1;
            out_item_next.out_byte = byte_sel;
            out_item_next.last     = job_end_reg && (job_idx_reg == job_len_reg - 6'd1);
            out_item_next.error    = (job_kind_reg == JOB_ERROR);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_format_reg <= 1'b0;
            channel_count_reg <= CHAN_RESET;
            frame_count_reg   <= 32'd0;
            settle_reg        <= 2'd2;
            mant_reg          <= RATE_RESET;
            expo_reg          <= EXP_TOP;
            norm_busy_reg     <= 1'b1;
            file_open_reg     <= 1'b0;
            samples_left_reg  <= 48'd0;
            fmt24_reg         <= 1'b0;
            pad_reg           <= 1'b0;
            in_valid_reg      <= 1'b0;
            job_valid_reg     <= 1'b0;
            job_kind_reg      <= JOB_HEADER;
            job_len_reg       <= 6'd1;
            job_idx_reg       <= 6'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            sample_format_reg <= sample_format_next;
            channel_count_reg <= channel_count_next;
            frame_count_reg   <= frame_count_next;
            settle_reg        <= settle_next;
            mant_reg          <= mant_next;
            expo_reg          <= expo_next;
            norm_busy_reg     <= norm_busy_next;
            file_open_reg     <= file_open_next;
            samples_left_reg  <= samples_left_next;
            fmt24_reg         <= fmt24_next;
            pad_reg           <= pad_next;
            in_valid_reg      <= in_valid_next;
            job_valid_reg     <= job_valid_next;
            job_kind_reg      <= job_kind_next;
            job_len_reg       <= job_len_next;
            job_idx_reg       <= job_idx_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        total_reg <= {16'd0, frame_count_reg} * {32'd0, channel_count_reg};
        sound_reg <= {1'b0, total_reg, 1'b0}
                     + (sample_format_reg ? {2'b00, total_reg} : 50'd0);
        if (in_fire)
        begin
            in_item_reg <= in_data;
        end
        job_val_reg    <= job_val_next;
        job_fmt24_reg  <= job_fmt24_next;
        job_end_reg    <= job_end_next;
        out_item_reg   <= out_item_next;
    end

    // Checks
    a_job_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_idx_reg < job_len_reg))
        else $error("job byte index beyond job length");

    a_open_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        file_open_reg == (samples_left_reg != 48'd0))
        else $error("file open flag disagrees with sample count");

    a_hold_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> !in_ready)
        else $error("item taken before derived sizes settled");

    a_hold_while_norm: assert property (@(posedge clk) disable iff (!rst_n)
        norm_busy_reg |-> !in_ready)
        else $error("item taken during leading-one search");

endmodule
